@@ sv/rrip_cache_replacement_assert.svh @@
// Assertion macros shared by the replacement state modules.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef RRIP_CACHE_REPLACEMENT_ASSERT_SVH
`define RRIP_CACHE_REPLACEMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRIP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rrip_pkg.sv @@
package rrip_pkg;

	// Geometry. NUM_SETS must be a power of two so that the set index wraps by masking.
	localparam int NUM_SETS = 2048;
	localparam int NUM_WAYS = 16;
	localparam int MAX_PRED = 3;

	localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int PRED_W = $clog2(MAX_PRED + 1);

	// Fixed field widths of the channels.
	localparam int SET_IDX_W = 11;
	localparam int WAY_IDX_W = 4;
	localparam int CHANCE_W  = 16;
	localparam int LFSR_W    = 16;

	localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'd44257;
	localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
	localparam logic [CHANCE_W-1:0] CHANCE_RESET = 16'd6554;

	localparam logic CMD_VICTIM = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam logic [PRED_W-1:0] PRED_MAX  = PRED_W'(MAX_PRED);
	localparam logic [PRED_W-1:0] PRED_FAR  = PRED_W'((MAX_PRED >= 1) ? MAX_PRED - 1 : 0);
	localparam logic [PRED_W-1:0] PRED_NEAR = PRED_W'((MAX_PRED >= 2) ? MAX_PRED - 2 : 0);
	localparam logic [PRED_W-1:0] PRED_HIT  = '0;

	typedef logic [NUM_WAYS-1:0][PRED_W-1:0] row_t;

	typedef struct packed {
		logic                 command;
		logic [SET_IDX_W-1:0] set_index;
		logic [WAY_IDX_W-1:0] way_index;
		logic                 is_hit;
		logic                 is_writeback;
	} req_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} status_t;

endpackage

@@ sv/rrip_if.sv @@
interface rrip_req_if;
	import rrip_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [SET_IDX_W-1:0] set_index;
	logic [WAY_IDX_W-1:0] way_index;
	logic                 is_hit;
	logic                 is_writeback;

	modport source (output valid, command, set_index, way_index, is_hit, is_writeback,
		input ready);
	modport sink (input valid, command, set_index, way_index, is_hit, is_writeback,
		output ready);
endinterface

interface rrip_vic_if;
	import rrip_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WAY_IDX_W-1:0] victim_way;

	modport source (output valid, victim_way, input ready);
	modport sink (input valid, victim_way, output ready);
endinterface

interface rrip_cfg_if;
	import rrip_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHANCE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/rrip_ctrl.sv @@
module rrip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrip_pkg::status_t st,
	output rrip_pkg::cmd_t    cmd
);
	import rrip_pkg::*;

	`include "rrip_cache_replacement_assert.svh"

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE) && !st.out_busy;
	assign cmd.clear = (state_q == ST_CLEAR);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (st.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	`RRIP_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec, "accepted request was not executed")
	`RRIP_ASSERT_SAME(a_exec_blocks_input, cmd.exec, !in_ready, "input ready during execute")
	`RRIP_ASSERT_SAME(a_clear_blocks_input, cmd.clear, !in_ready, "input ready during clear")

endmodule

@@ sv/rrip_dpath.sv @@
module rrip_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrip_pkg::cmd_t                 cmd,
	input  rrip_pkg::req_t                 req,
	input  logic                           cfg_valid,
	input  logic [rrip_pkg::CHANCE_W-1:0]  cfg_data,
	input  logic                           vic_ready,
	output logic                           vic_valid,
	output logic [rrip_pkg::WAY_IDX_W-1:0] vic_way,
	output rrip_pkg::status_t              st
);
	import rrip_pkg::*;

	`include "rrip_cache_replacement_assert.svh"

	// Prediction storage, one row of all ways per set.
	row_t mem_q [NUM_SETS];

	row_t                 rd_row_q;
	logic                 cmd_q;
	logic [SET_AW-1:0]    set_q;
	logic [WAY_IDX_W-1:0] way_q;
	logic                 hit_q;
	logic                 wb_q;

	logic [SET_AW-1:0]    clr_cnt_q;
	logic [LFSR_W-1:0]    lfsr_q;
	logic [CHANCE_W-1:0]  chance_q;
	logic                 vic_valid_q;
	logic [WAY_IDX_W-1:0] vic_way_q;

	logic [MAX_PRED:0]    level_seen;
	logic [PRED_W-1:0]    largest;
	logic [PRED_W-1:0]    age_add;
	logic [NUM_WAYS-1:0]  match;
	logic [NUM_WAYS-1:0]  first_hot;
	logic [WAY_W-1:0]     victim;
	row_t                 aged_row;
	row_t                 upd_row;
	logic                 way_ok;
	logic                 is_miss;
	logic [LFSR_W-1:0]    lfsr_nx;
	logic [PRED_W-1:0]    upd_val;

	logic                 mem_we;
	logic [SET_AW-1:0]    mem_waddr;
	row_t                 mem_wdata;

	// Aging: find the set's largest value, then lift every way by the gap to the maximum.
	// The first way that reaches the maximum is the one that held the largest value.
	always_comb begin
		level_seen = '0;
		for (int v = 0; v <= MAX_PRED; v++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (rd_row_q[w] == PRED_W'(v)) level_seen[v] = 1'b1;
			end
		end
		largest = '0;
		for (int v = 0; v <= MAX_PRED; v++) begin
			if (level_seen[v]) largest = PRED_W'(v);
		end
		age_add = PRED_MAX - largest;
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w]    = (rd_row_q[w] == largest);
			aged_row[w] = rd_row_q[w] + age_add;
		end
		first_hot = match & (~match + NUM_WAYS'(1));
		victim = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (first_hot[w]) victim = victim | WAY_W'(w);
		end
	end

	// Update path and the insertion draw.
	assign way_ok  = (int'(way_q) < NUM_WAYS);
	assign is_miss = !wb_q && !hit_q;
	assign lfsr_nx = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	always_comb begin
		if (wb_q) begin
			upd_val = PRED_FAR;
		end else if (hit_q) begin
			upd_val = PRED_HIT;
		end else if (lfsr_nx < chance_q) begin
			upd_val = PRED_NEAR;
		end else begin
			upd_val = PRED_FAR;
		end
		upd_row = rd_row_q;
		upd_row[WAY_W'(way_q)] = upd_val;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_q;
		mem_wdata = aged_row;
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = {NUM_WAYS{PRED_MAX}};
		end else if (cmd.exec) begin
			if (cmd_q == CMD_VICTIM) begin
				mem_we = 1'b1;
			end else begin
				mem_we    = way_ok;
				mem_wdata = upd_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_row_q <= mem_q[req.set_index[SET_AW-1:0]];
			cmd_q    <= req.command;
			set_q    <= req.set_index[SET_AW-1:0];
			way_q    <= req.way_index;
			hit_q    <= req.is_hit;
			wb_q     <= req.is_writeback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			lfsr_q      <= LFSR_SEED;
			chance_q    <= CHANCE_RESET;
			vic_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + SET_AW'(1);
			if (cfg_valid) chance_q <= cfg_data;
			if (cmd.exec && cmd_q == CMD_UPDATE && way_ok && is_miss) lfsr_q <= lfsr_nx;
			if (cmd.exec && cmd_q == CMD_VICTIM) begin
				vic_valid_q <= 1'b1;
			end else if (vic_ready) begin
				vic_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd_q == CMD_VICTIM) vic_way_q <= WAY_IDX_W'(victim);
	end

	assign vic_valid   = vic_valid_q;
	assign vic_way     = vic_way_q;
	assign st.clr_last = (clr_cnt_q == SET_AW'(NUM_SETS - 1));
	assign st.out_busy = vic_valid_q && !vic_ready;

	`RRIP_ASSERT_SAME(a_exec_out_free, cmd.exec, !vic_valid_q, "victim result would be overwritten")

endmodule

@@ sv/rrip_cache_replacement.sv @@
// Replacement state for a 2048-set, 16-way cache, with a 2-bit re-reference
// prediction value per way and bimodal insertion on missed fills.
// Channel req carries one request per transfer: command 0 asks for a victim in
// set_index, command 1 updates way_index of that set after a hit, writeback or fill.
// Channel victim returns victim_way, one transfer for each victim request; updates
// return nothing. Channel cfg writes the near insertion chance (1/65536 units);
// it is always ready and is meant to be written while no request is in flight.
// A request is read from the row memory at its transfer edge, aged or modified and
// written back in the next cycle, as a victim is captured in the output register;
// no new request is taken until that row read-modify-write is done.
// After reset the block clears every row to the maximum value, one row a cycle, and
// req.ready is low until it is done. The LFSR and chance register reset at once.
// When the receiver stalls, the finished victim waits in the output register and
// no new request is taken until that result is on its way.
module rrip_cache_replacement (
	input  logic       clk,
	input  logic       arst_n,
	rrip_req_if.sink   req,
	rrip_vic_if.source victim,
	rrip_cfg_if.sink   cfg
);
	import rrip_pkg::*;

	cmd_t    cmd;
	status_t st;
	req_t    req_data;

	// Gather the request payload into one bundle for the datapath.
	assign req_data.command      = req.command;
	assign req_data.set_index    = req.set_index;
	assign req_data.way_index    = req.way_index;
	assign req_data.is_hit       = req.is_hit;
	assign req_data.is_writeback = req.is_writeback;

	// The chance register takes every write in the cycle it arrives.
	assign cfg.ready = 1'b1;

	rrip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rrip_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req_data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.vic_ready (victim.ready),
		.vic_valid (victim.valid),
		.vic_way   (victim.victim_way),
		.st        (st)
	);

endmodule
